>>> rtl/gdfs_pkg.sv
// shared constants for the depth-first traversal block
package gdfs_pkg;

    localparam int VERTEX_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic ACT_ADD_EDGE = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

>>> rtl/gdfs_adj_mem.sv
// adjacency matrix memory, one row per vertex, rows read as zero until first written
module gdfs_adj_mem #(
    parameter int ROWS = 64,
    parameter int AW = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [AW-1:0]   rd_addr,
    output logic [ROWS-1:0] rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  logic [ROWS-1:0] wr_data
);

    logic [ROWS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic [ROWS-1:0] rd_data_reg;
    logic            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // row valid bits stand in for clearing the matrix at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/graph_depth_first_traversal.sv
// depth-first traversal over a bit adjacency matrix, top level
//
//  channel   handshake              word
//  input     start / busy           action, vertex_a, vertex_b
//  result    result_valid strobe    visited_vertex, last, error
//  config    apb psel/penable       vertex_count at byte address 0
//
//  add-edge word: row a read-modify-write, then row b
//  search: a push goes straight on to the next selection; a pop takes a stack read,
//    then an adjacency row read through the single memory read port
//  search start out of range: error word in the cycle after the start, block stays free
//  reset clears control state and the row valid bits, no clearing pass
//  results are shown for one cycle each and cannot be stalled
module graph_depth_first_traversal #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [gdfs_pkg::VERTEX_W-1:0]       vertex_a,
    input  logic [gdfs_pkg::VERTEX_W-1:0]       vertex_b,
    output logic                                result_valid,
    output logic [gdfs_pkg::VERTEX_W-1:0]       visited_vertex,
    output logic                                last,
    output logic                                error,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gdfs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gdfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gdfs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import gdfs_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > VERTEX_W) ? CW : VERTEX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_WA,
        ST_EDGE_WB,
        ST_SEL,
        ST_POP
    } state_t;

    state_t                state_reg;
    logic [VERTEX_W-1:0]   vertex_count_reg;
    logic [IW-1:0]         a_idx_reg;
    logic [IW-1:0]         b_idx_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [CW-1:0]         depth_reg;
    logic [VERTEX_W-1:0]   pend_reg;
    logic                  result_valid_reg;
    logic [VERTEX_W-1:0]   visited_vertex_reg;
    logic                  last_reg;
    logic                  error_reg;

    logic [IW-1:0]         stack_mem [MAX_VERTICES];
    logic [IW-1:0]         stack_rd_reg;
    logic                  stack_we;
    logic [IW-1:0]         stack_waddr;
    logic [IW-1:0]         stack_wdata;
    logic [CW-1:0]         depth_m2;
    logic [IW-1:0]         pop_addr;

    logic [NW-1:0]         n_eff;
    logic [NW-1:0]         vc_ext;
    logic [NW-1:0]         va_ext;
    logic [NW-1:0]         vb_ext;
    logic [NW-1:0]         va_m1;
    logic [NW-1:0]         vb_m1;
    logic [IW-1:0]         va_idx;
    logic [IW-1:0]         vb_idx;
    logic                  va_ok;
    logic                  vb_ok;
    logic                  accept;
    logic                  cfg_write;

    logic [MAX_VERTICES-1:0] row;
    logic [MAX_VERTICES-1:0] range_mask;
    logic [MAX_VERTICES-1:0] cand;
    logic [MAX_VERTICES-1:0] lowest;
    logic                  found;
    logic [IW-1:0]         sel_idx;
    logic [NW-1:0]         sel_ext;
    logic [VERTEX_W-1:0]   sel_vertex;

    logic [IW-1:0]         adj_rd_addr;
    logic                  adj_wr_en;
    logic [IW-1:0]         adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;

    // configuration port
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT)
        begin
            prdata = {{(APB_DATA_W-VERTEX_W){1'b0}}, vertex_count_reg};
        end
    end

    // range checks against the effective vertex count
    assign vc_ext = NW'(vertex_count_reg);
    assign n_eff  = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;
    assign va_ext = NW'(vertex_a);
    assign vb_ext = NW'(vertex_b);
    assign va_ok  = (va_ext != '0) && (va_ext <= n_eff);
    assign vb_ok  = (vb_ext != '0) && (vb_ext <= n_eff);
    assign va_m1  = va_ext - NW'(1);
    assign vb_m1  = vb_ext - NW'(1);
    assign va_idx = va_m1[IW-1:0];
    assign vb_idx = vb_m1[IW-1:0];

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // neighbour selection: lowest unvisited in-range bit of the current row
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            range_mask[i] = (NW'(i) < n_eff);
        end
    end

    assign cand   = row & ~visited_reg & range_mask;
    assign lowest = cand & (~cand + MAX_VERTICES'(1));
    assign found  = |cand;

    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (lowest[i])
            begin
                sel_idx = sel_idx | IW'(i);
            end
        end
    end

    assign sel_ext    = NW'(sel_idx) + NW'(1);
    assign sel_vertex = sel_ext[VERTEX_W-1:0];

    // adjacency memory port steering
    always_comb
    begin
        case (state_reg)
            ST_EDGE_WA: adj_rd_addr = b_idx_reg;
            ST_SEL:     adj_rd_addr = sel_idx;
            ST_POP:     adj_rd_addr = stack_rd_reg;
            default:    adj_rd_addr = va_idx;
        endcase
    end

    assign adj_wr_en   = (state_reg == ST_EDGE_WA) || (state_reg == ST_EDGE_WB);
    assign adj_wr_addr = (state_reg == ST_EDGE_WA) ? a_idx_reg : b_idx_reg;
    assign adj_wr_data = row | (MAX_VERTICES'(1) <<
                         ((state_reg == ST_EDGE_WA) ? b_idx_reg : a_idx_reg));

    gdfs_adj_mem #(
        .ROWS (MAX_VERTICES),
        .AW   (IW)
    ) u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (adj_rd_addr),
        .rd_data (row),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data)
    );

    // vertex stack
    assign depth_m2 = depth_reg - CW'(2);
    assign pop_addr = depth_m2[IW-1:0];

    always_comb
    begin
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = va_idx;
        if (accept && (action == ACT_SEARCH) && va_ok)
        begin
            stack_we = 1'b1;
        end
        else if ((state_reg == ST_SEL) && found)
        begin
            stack_we    = 1'b1;
            stack_waddr = depth_reg[IW-1:0];
            stack_wdata = sel_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[pop_addr];
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            visited_reg      <= '0;
            depth_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                vertex_count_reg <= pwdata[VERTEX_W-1:0];
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (action == ACT_ADD_EDGE)
                        begin
                            if (va_ok && vb_ok)
                            begin
                                state_reg <= ST_EDGE_WA;
                            end
                        end
                        else if (va_ok)
                        begin
                            visited_reg <= MAX_VERTICES'(1) << va_idx;
                            depth_reg   <= CW'(1);
                            state_reg   <= ST_SEL;
                        end
                        else
                        begin
                            result_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_EDGE_WA:
                begin
                    state_reg <= ST_EDGE_WB;
                end
                ST_EDGE_WB:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SEL:
                begin
                    if (found)
                    begin
                        result_valid_reg <= 1'b1;
                        visited_reg      <= visited_reg | lowest;
                        depth_reg        <= depth_reg + CW'(1);
                    end
                    else if (depth_reg == CW'(1))
                    begin
                        // stack runs empty: the held word goes out as the final one
                        result_valid_reg <= 1'b1;
                        depth_reg        <= '0;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - CW'(1);
                        state_reg <= ST_POP;
                    end
                end
                ST_POP:
                begin
                    state_reg <= ST_SEL;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers, one word held back so the final one can be marked
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_idx_reg          <= va_idx;
            b_idx_reg          <= vb_idx;
            pend_reg           <= vertex_a;
            visited_vertex_reg <= '0;
            last_reg           <= 1'b1;
            error_reg          <= 1'b1;
        end
        else if (state_reg == ST_SEL)
        begin
            visited_vertex_reg <= pend_reg;
            last_reg           <= !found;
            error_reg          <= 1'b0;
            if (found)
            begin
                pend_reg <= sel_vertex;
            end
        end
    end

    assign result_valid   = result_valid_reg;
    assign visited_vertex = visited_vertex_reg;
    assign last           = last_reg;
    assign error          = error_reg;

`ifndef NO_ASSERTIONS
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> last && (visited_vertex == '0))
        else $error("error word not marked final or carries a vertex");

    a_sel_stack_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) || (state_reg == ST_POP) |-> depth_reg != '0)
        else $error("search step with an empty stack");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CW'(MAX_VERTICES))
        else $error("stack depth beyond capacity");

    a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) && $past(state_reg == ST_SEL) |-> result_valid && last && !error)
        else $error("search ended without a final word");
`endif

endmodule
